// ===== rtl/ttup_pkg.sv =====
// Shared types and constants for the text to unsigned parser.
`timescale 1ns / 1ps
package ttup_pkg;

    localparam int OffsetBitsDefault = 16;
    localparam int CharW             = 8;
    localparam int BaseW             = 6;
    localparam int DigitW            = 6;
    localparam int ValueW            = 64;
    localparam int OutOffsetW        = 16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_FIRST,
        PH_ZERO,
        PH_HEXFIRST,
        PH_DIGITS
    } t_phase;

    localparam logic [CharW-1:0] CH_0     = 8'h30;
    localparam logic [CharW-1:0] CH_9     = 8'h39;
    localparam logic [CharW-1:0] CH_UA    = 8'h41;
    localparam logic [CharW-1:0] CH_UZ    = 8'h5A;
    localparam logic [CharW-1:0] CH_LA    = 8'h61;
    localparam logic [CharW-1:0] CH_LZ    = 8'h7A;
    localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
    localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CharW-1:0] CH_LX    = 8'h78;
    localparam logic [CharW-1:0] CH_UX    = 8'h58;
    localparam logic [CharW-1:0] CH_SPACE = 8'h20;
    localparam logic [CharW-1:0] CH_TAB   = 8'h09;
    localparam logic [CharW-1:0] CH_CR    = 8'h0D;

    // 'A' - 10 and 'a' - 10
    localparam logic [CharW-1:0] UPPER_BIAS = 8'd55;
    localparam logic [CharW-1:0] LOWER_BIAS = 8'd87;

    localparam logic [BaseW-1:0] BASE_AUTO = 6'd0;
    localparam logic [BaseW-1:0] BASE_OCT  = 6'd8;
    localparam logic [BaseW-1:0] BASE_DEC  = 6'd10;
    localparam logic [BaseW-1:0] BASE_HEX  = 6'd16;

    typedef struct packed {
        logic              ok;
        logic              carry;
        logic [ValueW-1:0] acc;
    } t_digit_res;

endpackage

// ===== rtl/ttup_char_if.sv =====
// Character request channel.
`timescale 1ns / 1ps
interface ttup_char_if;
    logic                           valid;
    logic                           ready;
    logic [ttup_pkg::CharW-1:0]     char_code;
    logic                           starts_string;

    modport source (output valid, output char_code, output starts_string, input ready);
    modport sink (input valid, input char_code, input starts_string, output ready);
endinterface

// ===== rtl/ttup_result_if.sv =====
// Conversion result channel.
`timescale 1ns / 1ps
interface ttup_result_if;
    logic                               valid;
    logic                               ready;
    logic [ttup_pkg::ValueW-1:0]        value;
    logic [ttup_pkg::OutOffsetW-1:0]    end_offset;
    logic                               overflowed;
    logic                               digits_seen;

    modport source (output valid, output value, output end_offset, output overflowed,
                    output digits_seen, input ready);
    modport sink (input valid, input value, input end_offset, input overflowed,
                  input digits_seen, output ready);
endinterface

// ===== rtl/ttup_cfg_if.sv =====
// Base register write channel.
`timescale 1ns / 1ps
interface ttup_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ttup_pkg::BaseW-1:0]     number_base;

    modport source (output valid, output number_base, input ready);
    modport sink (input valid, input number_base, output ready);
endinterface

// ===== rtl/text_to_unsigned_parser.sv =====
// Streaming text to unsigned 64-bit converter, top level.
// A character is registered in the input register; a finished result is registered in the result register.
// Throughput: one character per cycle while no result stalls; the step is one 64x6 multiply-add in a single pass.
// A character that ends a conversion stalls only while the result register is still full.
// Reset (synchronous, active low): idle, no string in progress, base register 0.
`timescale 1ns / 1ps
module text_to_unsigned_parser #(
    parameter int OFFSET_BITS = ttup_pkg::OffsetBitsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ttup_char_if.sink    i_char,
    ttup_cfg_if.sink     i_cfg,
    ttup_result_if.source o_result
);

    localparam logic [OFFSET_BITS-1:0] PosMax = '1;

    logic [ttup_pkg::BaseW-1:0] r_cfg_base;

    logic                       r_in_valid;
    logic [ttup_pkg::CharW-1:0] r_in_char;
    logic                       r_in_start;

    ttup_pkg::t_phase            r_phase, n_phase;
    logic [ttup_pkg::ValueW-1:0] r_acc, n_acc;
    logic [ttup_pkg::BaseW-1:0]  r_base, n_base;
    logic                        r_minus, n_minus;
    logic                        r_ovf, n_ovf;
    logic                        r_dig, n_dig;
    logic [OFFSET_BITS-1:0]      r_pos, n_pos;

    logic                            r_out_valid;
    logic [ttup_pkg::ValueW-1:0]     r_out_value;
    logic [ttup_pkg::OutOffsetW-1:0] r_out_offset;
    logic                            r_out_ovf;
    logic                            r_out_dig;

    ttup_pkg::t_phase            cur_phase;
    logic [ttup_pkg::ValueW-1:0] cur_acc;
    logic [ttup_pkg::BaseW-1:0]  cur_base;
    logic                        cur_minus, cur_ovf, cur_dig;
    logic [OFFSET_BITS-1:0]      cur_pos;

    ttup_pkg::t_phase            p_phase;
    logic [ttup_pkg::BaseW-1:0]  p_base;
    logic                        p_minus;
    logic                        p_pos_inc;
    logic                        p_zero_dig;
    logic                        p_first;
    logic                        do_digit;
    logic [ttup_pkg::BaseW-1:0]  td_base;
    logic                        is_ws;

    ttup_pkg::t_digit_res        dres;

    logic                        pos_inc;
    logic                        emit;
    logic                        advance;
    logic                        emit_dig;
    logic [31:0]                 pos_wide;
    logic [ttup_pkg::ValueW-1:0] emit_value;

    // Config register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base <= ttup_pkg::BASE_AUTO;
        end else if (i_cfg.valid) begin
            r_cfg_base <= i_cfg.number_base;
        end
    end

    // Input register
    assign i_char.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char  <= i_char.char_code;
            r_in_start <= i_char.starts_string;
        end
    end

    // Effective state: a string start restarts everything
    always_comb begin
        if (r_in_start) begin
            cur_phase = ttup_pkg::PH_LEAD;
            cur_acc   = '0;
            cur_base  = r_cfg_base;
            cur_minus = 1'b0;
            cur_ovf   = 1'b0;
            cur_dig   = 1'b0;
            cur_pos   = '0;
        end else begin
            cur_phase = r_phase;
            cur_acc   = r_acc;
            cur_base  = r_base;
            cur_minus = r_minus;
            cur_ovf   = r_ovf;
            cur_dig   = r_dig;
            cur_pos   = r_pos;
        end
    end

    // Leading whitespace, sign and prefix handling, selects the base for the digit step
    always_comb begin
        p_phase    = cur_phase;
        p_base     = cur_base;
        p_minus    = cur_minus;
        p_pos_inc  = 1'b0;
        p_zero_dig = 1'b0;
        p_first    = 1'b0;
        do_digit   = 1'b0;
        td_base    = cur_base;
        is_ws      = (r_in_char == ttup_pkg::CH_SPACE) ||
                     (r_in_char >= ttup_pkg::CH_TAB && r_in_char <= ttup_pkg::CH_CR);

        unique case (cur_phase)
            ttup_pkg::PH_IDLE: begin
                p_phase = ttup_pkg::PH_IDLE;
            end
            ttup_pkg::PH_LEAD: begin
                if (is_ws) begin
                    p_pos_inc = 1'b1;
                end else if (r_in_char == ttup_pkg::CH_MINUS ||
                             r_in_char == ttup_pkg::CH_PLUS) begin
                    p_minus   = (r_in_char == ttup_pkg::CH_MINUS);
                    p_phase   = ttup_pkg::PH_FIRST;
                    p_pos_inc = 1'b1;
                end else begin
                    p_first = 1'b1;
                end
            end
            ttup_pkg::PH_FIRST: begin
                p_first = 1'b1;
            end
            ttup_pkg::PH_ZERO: begin
                if (r_in_char == ttup_pkg::CH_LX || r_in_char == ttup_pkg::CH_UX) begin
                    p_base    = ttup_pkg::BASE_HEX;
                    p_phase   = ttup_pkg::PH_HEXFIRST;
                    p_pos_inc = 1'b1;
                end else begin
                    td_base    = (cur_base == ttup_pkg::BASE_AUTO) ? ttup_pkg::BASE_OCT
                                                                    : cur_base;
                    p_base     = td_base;
                    p_zero_dig = 1'b1;
                    do_digit   = 1'b1;
                end
            end
            ttup_pkg::PH_HEXFIRST, ttup_pkg::PH_DIGITS: begin
                do_digit = 1'b1;
            end
            default: begin
                p_phase = ttup_pkg::PH_IDLE;
            end
        endcase

        if (p_first) begin
            if ((cur_base == ttup_pkg::BASE_AUTO || cur_base == ttup_pkg::BASE_HEX) &&
                r_in_char == ttup_pkg::CH_0) begin
                p_phase   = ttup_pkg::PH_ZERO;
                p_pos_inc = 1'b1;
            end else begin
                td_base  = (cur_base == ttup_pkg::BASE_AUTO) ? ttup_pkg::BASE_DEC : cur_base;
                p_base   = td_base;
                do_digit = 1'b1;
            end
        end
    end

    ttup_digit_acc u_digit (
        .i_char (r_in_char),
        .i_base (td_base),
        .i_acc  (cur_acc),
        .o_res  (dres)
    );

    // Digit step and end of conversion
    always_comb begin
        n_phase = p_phase;
        n_base  = p_base;
        n_minus = p_minus;
        n_acc   = cur_acc;
        n_ovf   = cur_ovf;
        n_dig   = cur_dig || p_zero_dig;
        pos_inc = p_pos_inc;
        emit    = 1'b0;

        if (do_digit) begin
            if (dres.ok) begin
                if (cur_ovf || dres.carry) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = dres.acc;
                end
                n_dig   = 1'b1;
                n_phase = ttup_pkg::PH_DIGITS;
                pos_inc = 1'b1;
            end else begin
                emit    = 1'b1;
                n_phase = ttup_pkg::PH_IDLE;
            end
        end

        n_pos = (pos_inc && cur_pos != PosMax) ? cur_pos + 1'b1 : cur_pos;

        emit_dig = cur_dig || p_zero_dig;
        pos_wide = 32'(cur_pos);
        if (cur_ovf) begin
            emit_value = '1;
        end else if (cur_minus) begin
            emit_value = ttup_pkg::ValueW'(0) - cur_acc;
        end else begin
            emit_value = cur_acc;
        end
    end

    assign advance = r_in_valid && (!emit || !r_out_valid || o_result.ready);

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ttup_pkg::PH_IDLE;
        end else if (advance) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_minus <= n_minus;
            r_ovf   <= n_ovf;
            r_dig   <= n_dig;
            r_pos   <= n_pos;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_value  <= emit_value;
            r_out_offset <= emit_dig ? pos_wide[ttup_pkg::OutOffsetW-1:0] : '0;
            r_out_ovf    <= cur_ovf;
            r_out_dig    <= emit_dig;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.value       = r_out_value;
    assign o_result.end_offset  = r_out_offset;
    assign o_result.overflowed  = r_out_ovf;
    assign o_result.digits_seen = r_out_dig;

endmodule

// ===== rtl/ttup_digit_acc.sv =====
// Digit decode and multiply-accumulate step with carry-out detect.
`timescale 1ns / 1ps
module ttup_digit_acc (
    input  logic [ttup_pkg::CharW-1:0]  i_char,
    input  logic [ttup_pkg::BaseW-1:0]  i_base,
    input  logic [ttup_pkg::ValueW-1:0] i_acc,
    output ttup_pkg::t_digit_res        o_res
);

    localparam int ProdW = ttup_pkg::ValueW + ttup_pkg::BaseW;

    logic [ttup_pkg::CharW-1:0]  d8;
    logic                        is_dig;
    logic [ttup_pkg::DigitW-1:0] digit;
    logic [ProdW-1:0]            prod;
    logic [ProdW-1:0]            sum;

    always_comb begin
        if (i_char >= ttup_pkg::CH_0 && i_char <= ttup_pkg::CH_9) begin
            d8     = i_char - ttup_pkg::CH_0;
            is_dig = 1'b1;
        end else if (i_char >= ttup_pkg::CH_UA && i_char <= ttup_pkg::CH_UZ) begin
            d8     = i_char - ttup_pkg::UPPER_BIAS;
            is_dig = 1'b1;
        end else if (i_char >= ttup_pkg::CH_LA && i_char <= ttup_pkg::CH_LZ) begin
            d8     = i_char - ttup_pkg::LOWER_BIAS;
            is_dig = 1'b1;
        end else begin
            d8     = '0;
            is_dig = 1'b0;
        end
        digit = d8[ttup_pkg::DigitW-1:0];

        prod = ProdW'(i_acc) * ProdW'(i_base);
        sum  = prod + ProdW'(digit);

        o_res.ok    = is_dig && (digit < i_base);
        o_res.carry = |sum[ProdW-1:ttup_pkg::ValueW];
        o_res.acc   = sum[ttup_pkg::ValueW-1:0];
    end

endmodule
